/* hw/rtl/btpc_pkg.sv */
// shared types and helpers for the barometric compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;
    localparam int CalW = 48;
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] RegCalTemp = 2'd0;
    localparam logic [CfgIdxW-1:0] RegCalPressA = 2'd1;
    localparam logic [CfgIdxW-1:0] RegCalPressB = 2'd2;
    localparam logic [CfgIdxW-1:0] RegCalPressC = 2'd3;
    localparam int DivSteps = 32;

    // sign-extended calibration word
    function automatic logic [31:0] sw(input logic [15:0] w);
        sw = {{16{w[15]}}, w};
    endfunction

    // low 32 bits of a product of two 32-bit patterns
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

    // arithmetic right shift of a 32-bit two's complement pattern
    function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
        asr32 = $unsigned($signed(x) >>> s);
    endfunction

    // stage payload of the divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] num;
        logic [31:0] den;
        logic        hi_path;
        logic        ok;
        logic [31:0] fine;
        logic [31:0] centi;
    } div_item_t;
endpackage
`default_nettype wire

/* hw/rtl/btpc_div_stage.sv */
// one restoring-division step of the pipelined unsigned divider
`timescale 1ns / 1ps
`default_nettype none
module btpc_div_stage (
    input  var btpc_pkg::div_item_t d_in,
    output var btpc_pkg::div_item_t d_out
);
    logic [32:0] trial;
    logic [32:0] shifted;
    always_comb begin
        d_out = d_in;
        shifted = {d_in.rem, d_in.num[31]};
        trial = shifted - {1'b0, d_in.den};
        d_out.num = {d_in.num[30:0], 1'b0};
        if (!trial[32]) begin
            d_out.rem = trial[31:0];
            d_out.quo = {d_in.quo[30:0], 1'b1};
        end else begin
            d_out.rem = shifted[31:0];
            d_out.quo = {d_in.quo[30:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/baro_temp_pressure_compensation_top.sv */
// top level of the barometric temperature and pressure compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw temperature/pressure pair per cycle and returns fine temperature,
// centidegrees and pressure in pascals with the 32-bit integer compensation.
// Fully pipelined: one transfer per cycle sustained while m_axis is not stalled,
// through the 9 arithmetic stages, the 32-step divider, the 4 correction stages
// and 4 output delay stages. A stall on m_axis freezes the whole pipeline.
// Calibration registers must be written by the user only while the pipeline is
// empty; the block itself does not enforce this.
module baro_temp_pressure_compensation_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [103:0] m_axis_tdata, // fine_temperature, temperature_centi,
                                       // pressure_pa, pressure_valid, zero fill
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [47:0] cfg_wdata
);
    localparam int PreN = 9;
    localparam int PostN = 8;
    localparam int TotN = PreN + btpc_pkg::DivSteps + PostN;

    logic [47:0] cal_temp_reg, cal_pa_reg, cal_pb_reg, cal_pc_reg;
    logic [TotN-1:0] vld_reg;
    logic adv;
    assign adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[TotN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg <= '0; cal_pa_reg <= '0; cal_pb_reg <= '0; cal_pc_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                btpc_pkg::RegCalTemp:   cal_temp_reg <= cfg_wdata;
                btpc_pkg::RegCalPressA: cal_pa_reg <= cfg_wdata;
                btpc_pkg::RegCalPressB: cal_pb_reg <= cfg_wdata;
                btpc_pkg::RegCalPressC: cal_pc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[TotN-2:0], s_axis_tvalid};
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, cal_temp_reg[15:0]};
    assign t2 = btpc_pkg::sw(cal_temp_reg[31:16]);
    assign t3 = btpc_pkg::sw(cal_temp_reg[47:32]);
    assign p1 = {16'd0, cal_pa_reg[15:0]};
    assign p2 = btpc_pkg::sw(cal_pa_reg[31:16]);
    assign p3 = btpc_pkg::sw(cal_pa_reg[47:32]);
    assign p4 = btpc_pkg::sw(cal_pb_reg[15:0]);
    assign p5 = btpc_pkg::sw(cal_pb_reg[31:16]);
    assign p6 = btpc_pkg::sw(cal_pb_reg[47:32]);
    assign p7 = btpc_pkg::sw(cal_pc_reg[15:0]);
    assign p8 = btpc_pkg::sw(cal_pc_reg[31:16]);
    assign p9 = btpc_pkg::sw(cal_pc_reg[47:32]);

    // front stages: temperature and divisor / dividend
    logic [31:0] a1_x_reg, a1_d_reg, a1_ap_reg;
    logic [31:0] a2_v1_reg, a2_dd_reg, a2_ap_reg;
    logic [31:0] a3_v1_reg, a3_v2_reg, a3_ap_reg;
    logic [31:0] a4_fine_reg, a4_ap_reg;
    logic [31:0] a5_fine_reg, a5_c_reg, a5_v1_reg, a5_q_reg, a5_ap_reg;
    logic [31:0] a6_fine_reg, a6_c_reg, a6_v1_reg, a6_v2a_reg, a6_v2b_reg,
                 a6_w3_reg, a6_w2_reg, a6_ap_reg;
    logic [31:0] a7_fine_reg, a7_c_reg, a7_v2_reg, a7_v1_reg, a7_ap_reg;
    logic [31:0] a8_fine_reg, a8_c_reg, a8_v1_reg, a8_n_reg;
    logic [31:0] a9_fine_reg, a9_c_reg, a9_v1_reg, a9_p_reg;
    logic [31:0] at, ap, n_next, v1_next;
    assign at = {12'd0, s_axis_tdata[19:0]};
    assign ap = {12'd0, s_axis_tdata[39:20]};

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_x_reg <= (at >> 3) - (t1 << 1);
            a1_d_reg <= (at >> 4) - t1;
            a1_ap_reg <= ap;
            a2_v1_reg <= $signed(btpc_pkg::mul32(a1_x_reg, t2)) >>> 11;
            a2_dd_reg <= $signed(btpc_pkg::mul32(a1_d_reg, a1_d_reg)) >>> 12;
            a2_ap_reg <= a1_ap_reg;
            a3_v1_reg <= a2_v1_reg;
            a3_v2_reg <= $signed(btpc_pkg::mul32(a2_dd_reg, t3)) >>> 14;
            a3_ap_reg <= a2_ap_reg;
            a4_fine_reg <= a3_v1_reg + a3_v2_reg;
            a4_ap_reg <= a3_ap_reg;
            a5_fine_reg <= a4_fine_reg;
            a5_c_reg <= $signed(btpc_pkg::mul32(a4_fine_reg, 32'd5) + 32'd128) >>> 8;
            a5_v1_reg <= btpc_pkg::asr32(a4_fine_reg, 1) - 32'd64000;
            a5_q_reg <= btpc_pkg::asr32(btpc_pkg::asr32(a4_fine_reg, 1) - 32'd64000, 2);
            a5_ap_reg <= a4_ap_reg;
            a6_fine_reg <= a5_fine_reg;
            a6_c_reg <= a5_c_reg;
            a6_v1_reg <= a5_v1_reg;
            a6_v2a_reg <= btpc_pkg::mul32(a5_q_reg, a5_q_reg);
            a6_v2b_reg <= btpc_pkg::mul32(a5_v1_reg, p5) << 1;
            a6_w2_reg <= $signed(btpc_pkg::mul32(p2, a5_v1_reg)) >>> 1;
            a6_w3_reg <= '0;
            a6_ap_reg <= a5_ap_reg;
            a7_fine_reg <= a6_fine_reg;
            a7_c_reg <= a6_c_reg;
            a7_v2_reg <= btpc_pkg::asr32(btpc_pkg::mul32(btpc_pkg::asr32(a6_v2a_reg, 11), p6)
                          + a6_v2b_reg, 2) + (p4 << 16);
            a7_v1_reg <= btpc_pkg::asr32(btpc_pkg::asr32(btpc_pkg::mul32(p3,
                          btpc_pkg::asr32(a6_v2a_reg, 13)), 3) + a6_w2_reg + a6_w3_reg, 18);
            a7_ap_reg <= a6_ap_reg;
            a8_fine_reg <= a7_fine_reg;
            a8_c_reg <= a7_c_reg;
            a8_v1_reg <= v1_next;
            a8_n_reg <= (32'd1048576 - a7_ap_reg) - btpc_pkg::asr32(a7_v2_reg, 12);
            a9_fine_reg <= a8_fine_reg;
            a9_c_reg <= a8_c_reg;
            a9_v1_reg <= a8_v1_reg;
            a9_p_reg <= n_next;
        end
    end
    assign v1_next = $signed(btpc_pkg::mul32(32'd32768 + a7_v1_reg, p1)) >>> 15;
    assign n_next = btpc_pkg::mul32(a8_n_reg, 32'd3125);

    // divider chain
    btpc_pkg::div_item_t div_in, div_out;
    btpc_pkg::div_item_t dstage_reg [btpc_pkg::DivSteps];
    btpc_pkg::div_item_t dcomb [btpc_pkg::DivSteps];
    always_comb begin
        div_in.rem = '0;
        div_in.quo = '0;
        div_in.hi_path = a9_p_reg[31];
        div_in.num = a9_p_reg[31] ? a9_p_reg : {a9_p_reg[30:0], 1'b0};
        div_in.den = a9_v1_reg;
        div_in.ok = (a9_v1_reg != 32'd0);
        div_in.fine = a9_fine_reg;
        div_in.centi = a9_c_reg;
    end
    for (genvar g = 0; g < btpc_pkg::DivSteps; g++) begin : g_div
        btpc_div_stage u_stage (
            .d_in (g == 0 ? div_in : dstage_reg[g == 0 ? 0 : g-1]),
            .d_out(dcomb[g])
        );
        always_ff @(posedge aclk) begin
            if (adv) dstage_reg[g] <= dcomb[g];
        end
    end
    assign div_out = dstage_reg[btpc_pkg::DivSteps-1];

    // correction stages
    logic [31:0] c1_p_reg, c1_f_reg, c1_c_reg; logic c1_ok_reg;
    logic [31:0] c2_p_reg, c2_f_reg, c2_c_reg, c2_sq_reg, c2_v2_reg; logic c2_ok_reg;
    logic [31:0] c3_p_reg, c3_f_reg, c3_c_reg, c3_v1_reg, c3_v2_reg; logic c3_ok_reg;
    logic [31:0] c4_p_reg, c4_f_reg, c4_c_reg; logic c4_ok_reg;
    logic [31:0] q;
    assign q = div_out.hi_path ? (div_out.quo << 1) : div_out.quo;
    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_p_reg <= q; c1_f_reg <= div_out.fine; c1_c_reg <= div_out.centi;
            c1_ok_reg <= div_out.ok;
            c2_p_reg <= c1_p_reg; c2_f_reg <= c1_f_reg; c2_c_reg <= c1_c_reg;
            c2_ok_reg <= c1_ok_reg;
            c2_sq_reg <= btpc_pkg::mul32(c1_p_reg >> 3, c1_p_reg >> 3) >> 13;
            c2_v2_reg <= $signed(btpc_pkg::mul32(c1_p_reg >> 2, p8)) >>> 13;
            c3_p_reg <= c2_p_reg; c3_f_reg <= c2_f_reg; c3_c_reg <= c2_c_reg;
            c3_ok_reg <= c2_ok_reg;
            c3_v1_reg <= $signed(btpc_pkg::mul32(p9, c2_sq_reg)) >>> 12;
            c3_v2_reg <= c2_v2_reg;
            c4_f_reg <= c3_f_reg; c4_c_reg <= c3_c_reg; c4_ok_reg <= c3_ok_reg;
            c4_p_reg <= c3_ok_reg
                        ? c3_p_reg + btpc_pkg::asr32(c3_v1_reg + c3_v2_reg + p7, 4)
                        : 32'd0;
        end
    end
    // output delay stages
    logic [103:0] tail_reg [PostN-4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            tail_reg[0] <= {7'd0, c4_ok_reg, c4_p_reg, c4_c_reg, c4_f_reg};
            for (int i = 1; i < PostN-4; i++) tail_reg[i] <= tail_reg[i-1];
        end
    end
    assign m_axis_tdata = tail_reg[PostN-5];
endmodule
`default_nettype wire

/* hw/rtl/btpc_checker.sv */
// port-level checks on the compensation block
`timescale 1ns / 1ps
`default_nettype none
module btpc_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [103:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped during stall");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready not tied to output flow");
    a_inv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[96] |-> m_axis_tdata[95:64] == 32'd0)
        else $error("invalid pressure not zero");
    a_rst: assert property (@(posedge aclk) $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule
bind baro_temp_pressure_compensation_top btpc_checker u_chk (.*);
`default_nettype wire
